@@ rtl/core/cshash_pkg.sv @@
// Package for the context symbol count hash table.
// Holds field widths, command and status codes, and the pair-key mix constants.
package cshash_pkg;

    localparam int TableDepth = 1024;
    localparam int KeyW       = 64;
    localparam int CountW     = 32;
    localparam int DistW      = 17;
    localparam int SymW       = 16;

    localparam logic [63:0] MixAdd = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MixMul = 64'hBF58_476D_1CE4_E5B9;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_UNUSED   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_MIX1,
        S_MIX2,
        S_MIX3,
        S_MIX4,
        S_MIX5,
        S_CREAD,
        S_CCHK,
        S_PREAD,
        S_PCHK,
        S_WRITE,
        S_OUT
    } t_state;

    // Context entry: key, counters and last symbol; pair entry: key plus count.
    typedef struct packed {
        logic [KeyW-1:0]   key;
        logic [CountW-1:0] total;
        logic [DistW-1:0]  distinct;
        logic [SymW-1:0]   last;
    } t_ctx_entry;

    typedef struct packed {
        logic [KeyW-1:0]   key;
        logic [CountW-1:0] count;
    } t_pair_entry;

    function automatic logic [63:0] home_base(input logic [63:0] key);
        return key ^ (key >> 29);
    endfunction

endpackage

@@ rtl/core/cshash_if.sv @@
// Valid/ready channel interface carrying one word of payload.
// Depends on nothing; the payload type is a parameter.
interface cshash_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/context_symbol_count_hash_table_top.sv @@
// Top level of the context symbol count hash table.
// Depends on cshash_pkg, cshash_if and cshash_ram.
//
// Usage: the input channel carries one word {cmd, ctx_key, symbol}; the
// output channel returns one word {status, ctx_total, ctx_distinct,
// last_symbol, pair_count} per input word, in order.
// Commands: add counts the symbol under the context, lookup reads the
// context fields and the pair count, clear empties both tables.
// One word is worked on at a time. A lookup or add runs the pair-key mix
// (split 32x32 partial products) through S_MIX1 to S_MIX5, then, for each
// probed slot in each table, a memory read state (registered read) and a
// compare state, then the write state and the output state. The unused
// command goes from S_MIX1 straight to the write and output states,
// skipping the rest of the mix and the probes. Each table lives in a
// single-port RAM. Reset, and the clear command, run a clearing pass over
// every address of both RAMs, during which no word is accepted.
// The result sits in an output register; a stalled receiver holds it there
// and the block takes no new word until it is taken.
module context_symbol_count_hash_table_top #(
    parameter int TABLE_DEPTH = cshash_pkg::TableDepth
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cshash_if.sink   i_in,
    cshash_if.source o_out
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $bits(cshash_pkg::t_ctx_entry);
    localparam int PW = $bits(cshash_pkg::t_pair_entry);
    localparam logic [AW:0] ProbeMax = (AW+1)'(TABLE_DEPTH);

    cshash_pkg::t_state r_state, n_state;

    logic [1:0]  r_cmd;
    logic [63:0] r_ck;
    logic [15:0] r_sym;
    logic [63:0] r_h, r_pk;
    logic [31:0] r_pp0, r_pp1, r_pp2;
    logic [AW-1:0] r_addr, r_cslot, r_pslot;
    logic [AW:0]   r_cnt;
    logic r_cfound, r_cmatch, r_pfound, r_pmatch;
    cshash_pkg::t_ctx_entry  r_centry;
    cshash_pkg::t_pair_entry r_pentry;
    logic [1:0]  r_status;
    logic [31:0] r_total, r_pcount;
    logic [16:0] r_dist;
    logic [15:0] r_last;
    logic        r_ovalid;

    logic c_we, p_we;
    logic [AW-1:0] c_addr, p_addr;
    logic [CW-1:0] c_wdata, c_rdata;
    logic [PW-1:0] p_wdata, p_rdata;
    cshash_pkg::t_ctx_entry  c_rd, c_new;
    cshash_pkg::t_pair_entry p_rd, p_new;

    assign c_rd = cshash_pkg::t_ctx_entry'(c_rdata);
    assign p_rd = cshash_pkg::t_pair_entry'(p_rdata);

    cshash_ram #(.Width(CW), .Depth(TABLE_DEPTH)) u_ctx_ram (
        .i_clk(i_clk), .i_we(c_we), .i_addr(c_addr),
        .i_wdata(c_wdata), .o_rdata(c_rdata)
    );
    cshash_ram #(.Width(PW), .Depth(TABLE_DEPTH)) u_pair_ram (
        .i_clk(i_clk), .i_we(p_we), .i_addr(p_addr),
        .i_wdata(p_wdata), .o_rdata(p_rdata)
    );

    assign i_in.ready  = (r_state == cshash_pkg::S_IDLE) && !r_ovalid;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = {r_status, r_total, r_dist, r_last, r_pcount};

    // Updated entries on add, computed from the probed slots.
    always_comb begin
        c_new = r_centry;
        p_new = r_pentry;
        if (!r_cmatch) begin
            c_new = '0;
        end
        if (!r_pmatch) begin
            p_new = '0;
        end
        c_new.key = r_ck;
        p_new.key = r_pk;
        if (p_new.count == '0 && c_new.distinct != '1) begin
            c_new.distinct = c_new.distinct + 17'd1;
        end
        if (p_new.count != '1) begin
            p_new.count = p_new.count + 32'd1;
        end
        if (c_new.total != '1) begin
            c_new.total = c_new.total + 32'd1;
        end
        c_new.last = r_sym;
    end

    always_comb begin
        c_we = 1'b0;
        p_we = 1'b0;
        c_addr = r_addr;
        p_addr = r_addr;
        c_wdata = '0;
        p_wdata = '0;
        n_state = r_state;
        case (r_state)
            cshash_pkg::S_IDLE: begin
                if (i_in.valid && i_in.ready) begin
                    n_state = cshash_pkg::S_MIX1;
                end
            end
            cshash_pkg::S_CLEAR: begin
                c_we = 1'b1;
                p_we = 1'b1;
                if (r_addr == '1) begin
                    n_state = (r_cmd == cshash_pkg::CMD_CLEAR) ?
                              cshash_pkg::S_OUT : cshash_pkg::S_IDLE;
                end
            end
            cshash_pkg::S_MIX1: begin
                // Clear and unused commands skip the probes.
                if (r_cmd == cshash_pkg::CMD_CLEAR) begin
                    n_state = cshash_pkg::S_CLEAR;
                end else if (r_cmd == cshash_pkg::CMD_NOP) begin
                    n_state = cshash_pkg::S_WRITE;
                end else begin
                    n_state = cshash_pkg::S_MIX2;
                end
            end
            cshash_pkg::S_MIX2: n_state = cshash_pkg::S_MIX3;
            cshash_pkg::S_MIX3: n_state = cshash_pkg::S_MIX4;
            cshash_pkg::S_MIX4: n_state = cshash_pkg::S_MIX5;
            cshash_pkg::S_MIX5: n_state = cshash_pkg::S_CREAD;
            cshash_pkg::S_CREAD: n_state = cshash_pkg::S_CCHK;
            cshash_pkg::S_CCHK: begin
                if (c_rd.key == r_ck || c_rd.key == '0 || r_cnt == ProbeMax - 1'b1) begin
                    n_state = cshash_pkg::S_PREAD;
                end else begin
                    n_state = cshash_pkg::S_CREAD;
                end
            end
            cshash_pkg::S_PREAD: n_state = cshash_pkg::S_PCHK;
            cshash_pkg::S_PCHK: begin
                if (p_rd.key == r_pk || p_rd.key == '0 || r_cnt == ProbeMax - 1'b1) begin
                    n_state = cshash_pkg::S_WRITE;
                end else begin
                    n_state = cshash_pkg::S_PREAD;
                end
            end
            cshash_pkg::S_WRITE: begin
                if (r_cmd == cshash_pkg::CMD_ADD && r_cfound && r_pfound) begin
                    c_we = 1'b1;
                    p_we = 1'b1;
                    c_addr = r_cslot;
                    p_addr = r_pslot;
                    c_wdata = CW'(c_new);
                    p_wdata = PW'(p_new);
                end
                n_state = cshash_pkg::S_OUT;
            end
            cshash_pkg::S_OUT: n_state = cshash_pkg::S_IDLE;
            default: n_state = cshash_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cshash_pkg::S_CLEAR;
            r_addr   <= '0;
            r_ovalid <= 1'b0;
            r_cmd    <= cshash_pkg::CMD_NOP;
        end else begin
            r_state <= n_state;
            if (o_out.valid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                cshash_pkg::S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_cmd <= i_in.data[80:79];
                        r_ck  <= {1'b1, i_in.data[78:16]};
                        r_sym <= i_in.data[15:0];
                        r_addr <= '0;
                    end
                end
                cshash_pkg::S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                end
                cshash_pkg::S_MIX1: begin
                    // h ^= (v + 7) + add + (h << 6) + (h >> 2)
                    r_h <= r_ck ^ (64'(r_sym) + 64'd7 + cshash_pkg::MixAdd
                                   + (r_ck << 6) + (r_ck >> 2));
                    if (r_cmd == cshash_pkg::CMD_CLEAR) begin
                        r_addr <= '0;
                    end
                end
                cshash_pkg::S_MIX2: begin
                    r_pp0 <= 32'(64'(r_h[31:0]) * 64'(cshash_pkg::MixMul[31:0]) >> 0);
                    r_pp1 <= 32'((64'(r_h[31:0]) * 64'(cshash_pkg::MixMul[31:0])) >> 32);
                end
                cshash_pkg::S_MIX3: begin
                    r_pp2 <= r_pp1 + r_h[31:0] * cshash_pkg::MixMul[63:32];
                end
                cshash_pkg::S_MIX4: begin
                    r_pk <= {r_pp2 + r_h[63:32] * cshash_pkg::MixMul[31:0], r_pp0};
                end
                cshash_pkg::S_MIX5: begin
                    r_pk   <= (r_pk ^ (r_pk >> 31)) | 64'h8000_0000_0000_0000;
                    r_addr <= AW'(cshash_pkg::home_base(r_ck));
                    r_cnt  <= '0;
                end
                cshash_pkg::S_CCHK: begin
                    r_centry <= c_rd;
                    r_cslot  <= r_addr;
                    r_cmatch <= (c_rd.key == r_ck);
                    r_cfound <= (c_rd.key == r_ck) || (c_rd.key == '0);
                    if (n_state == cshash_pkg::S_PREAD) begin
                        r_addr <= AW'(cshash_pkg::home_base(r_pk));
                        r_cnt  <= '0;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                        r_cnt  <= r_cnt + 1'b1;
                    end
                end
                cshash_pkg::S_PCHK: begin
                    r_pentry <= p_rd;
                    r_pslot  <= r_addr;
                    r_pmatch <= (p_rd.key == r_pk);
                    r_pfound <= (p_rd.key == r_pk) || (p_rd.key == '0);
                    r_addr <= r_addr + 1'b1;
                    r_cnt  <= r_cnt + 1'b1;
                end
                cshash_pkg::S_WRITE: begin
                    r_status <= cshash_pkg::ST_OK;
                    r_total  <= '0;
                    r_dist   <= '0;
                    r_last   <= '0;
                    r_pcount <= '0;
                    if (r_cmd == cshash_pkg::CMD_ADD) begin
                        if (r_cfound && r_pfound) begin
                            r_total  <= c_new.total;
                            r_dist   <= c_new.distinct;
                            r_last   <= c_new.last;
                            r_pcount <= p_new.count;
                        end else begin
                            r_status <= cshash_pkg::ST_FULL;
                        end
                    end else if (r_cmd == cshash_pkg::CMD_LOOKUP) begin
                        if (r_cmatch) begin
                            r_total <= r_centry.total;
                            r_dist  <= r_centry.distinct;
                            r_last  <= r_centry.last;
                        end else begin
                            r_status <= cshash_pkg::ST_NOTFOUND;
                        end
                        if (r_pmatch) begin
                            r_pcount <= r_pentry.count;
                        end
                    end
                end
                cshash_pkg::S_OUT: begin
                    if (r_cmd == cshash_pkg::CMD_CLEAR) begin
                        r_status <= cshash_pkg::ST_OK;
                        r_total  <= '0;
                        r_dist   <= '0;
                        r_last   <= '0;
                        r_pcount <= '0;
                    end
                    r_ovalid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // A result word never appears while a probe is still running.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == cshash_pkg::S_OUT)
        else $error("result raised outside the output step");

    // Nothing is written to the tables when a probe ran out of slots.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cshash_pkg::S_WRITE && !(r_cfound && r_pfound)) |-> !c_we && !p_we)
        else $error("write after a full probe");

    // The probe counter never passes the table depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cshash_pkg::S_CCHK || r_state == cshash_pkg::S_PCHK) |-> r_cnt < ProbeMax)
        else $error("probe ran past the table");
endmodule

@@ rtl/core/cshash_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module cshash_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
